// ----- hw/rtl/nms_pkg.sv -----
// Shared types and constants for the box non-maximum suppression block.
`timescale 1ns / 1ps

package nms_pkg;

  // One stored candidate box, as it sits in a memory word.
  typedef struct packed {
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } box_t;

  localparam int BoxBits = 64;
  localparam logic [15:0] ThreshReset = 16'd6554;

  // Sequencer states.
  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_SUPP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

endpackage

// ----- hw/rtl/nms_if.sv -----
// Handshake channel interfaces for candidate boxes, kept boxes and the threshold.
`timescale 1ns / 1ps

interface nms_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] box_x;
  logic [15:0] box_y;
  logic [15:0] box_width;
  logic [15:0] box_height;
  logic        last_box;
  modport source (output valid, box_x, box_y, box_width, box_height, last_box,
                  input ready);
  modport sink (input valid, box_x, box_y, box_width, box_height, last_box,
                output ready);
endinterface

interface nms_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] kept_x;
  logic [15:0] kept_y;
  logic [15:0] kept_width;
  logic [15:0] kept_height;
  logic        last_kept;
  logic        overflow;
  modport source (output valid, kept_x, kept_y, kept_width, kept_height, last_kept,
                  overflow, input ready);
  modport sink (input valid, kept_x, kept_y, kept_width, kept_height, last_kept,
                overflow, output ready);
endinterface

interface nms_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] overlap_threshold;
  modport source (output valid, overlap_threshold, input ready);
  modport sink (input valid, overlap_threshold, output ready);
endinterface

// ----- hw/rtl/nms_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module nms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/nms_iou.sv -----
// Pipelined exact intersection-over-union suppression test against the kept box.
`timescale 1ns / 1ps

module nms_iou #(
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_v,
  input  logic [IDX_W-1:0] in_idx,
  input  nms_pkg::box_t    other,
  input  nms_pkg::box_t    kept,
  input  logic [31:0]      kept_area,
  input  logic [15:0]      thr,
  output logic             res_v,
  output logic [IDX_W-1:0] res_idx,
  output logic             res_sup,
  output logic             busy
);
  import nms_pkg::*;

  logic [3:0]       v_r, v_nxt;
  logic [IDX_W-1:0] idx1_r, idx2_r, idx3_r, idx4_r;
  logic [15:0]      dx_r, dy_r, bw_r, bh_r;
  logic [31:0]      inter2_r, areab_r, inter3_r, inter4_r;
  logic [33:0]      uni_r;
  logic [49:0]      prod_r;

  logic [16:0] ax2, bx2, ay2, by2, x1, x2, y1, y2;
  logic [16:0] dxw, dyw;

  // Overlap extents of the two boxes; edges at 17 bits so they do not wrap.
  always_comb begin
    ax2 = {1'b0, kept.x} + {1'b0, kept.w};
    bx2 = {1'b0, other.x} + {1'b0, other.w};
    ay2 = {1'b0, kept.y} + {1'b0, kept.h};
    by2 = {1'b0, other.y} + {1'b0, other.h};
    x1  = (kept.x > other.x) ? {1'b0, kept.x} : {1'b0, other.x};
    y1  = (kept.y > other.y) ? {1'b0, kept.y} : {1'b0, other.y};
    x2  = (ax2 < bx2) ? ax2 : bx2;
    y2  = (ay2 < by2) ? ay2 : by2;
    dxw = (x2 > x1 && y2 > y1) ? x2 - x1 : 17'd0;
    dyw = (x2 > x1 && y2 > y1) ? y2 - y1 : 17'd0;
  end

  assign v_nxt = {v_r[2:0], in_v};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Stage 1 extents, stage 2 products, stage 3 union, stage 4 threshold product.
  always_ff @(posedge clk) begin
    idx1_r   <= in_idx;
    dx_r     <= dxw[15:0];
    dy_r     <= dyw[15:0];
    bw_r     <= other.w;
    bh_r     <= other.h;
    idx2_r   <= idx1_r;
    inter2_r <= dx_r * dy_r;
    areab_r  <= bw_r * bh_r;
    idx3_r   <= idx2_r;
    inter3_r <= inter2_r;
    uni_r    <= {2'b0, kept_area} + {2'b0, areab_r} - {2'b0, inter2_r};
    idx4_r   <= idx3_r;
    inter4_r <= inter3_r;
    prod_r   <= {34'd0, thr} * {16'd0, uni_r};
  end

  // Exact test: inter * 65536 > thr * union.
  assign res_v   = v_r[3];
  assign res_idx = idx4_r;
  assign res_sup = {2'b0, inter4_r, 16'd0} > prod_r;
  assign busy    = |v_r;

endmodule

// ----- hw/rtl/box_non_max_suppression.sv -----
// Top level of the greedy box non-maximum suppression block.
`timescale 1ns / 1ps

// Candidate boxes are taken one beat a cycle and written to a box memory until the
// beat flagged last_box; beats beyond MAX_BOXES are dropped and flag overflow on
// every kept box of that set. Suppression then repeats one round per kept box: a
// scan over the N stored entries through the memory's single read port picks
// the alive box with the greatest bottom edge, later box winning ties, and a
// suppression sweep over the same N entries through a four-stage IoU pipeline
// retires overlapping boxes, after which the kept box is placed in the output
// register. The next set's first box is accepted only once the set's last kept
// box has been placed. The threshold is written on its own channel, which is
// always ready.
module box_non_max_suppression #(
  parameter int MAX_BOXES = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  nms_in_if.sink    in_box,
  nms_out_if.source out_box,
  nms_cfg_if.sink   cfg_thr
);
  import nms_pkg::*;

  localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(MAX_BOXES);

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     iss_r, iss_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [MAX_BOXES-1:0] alive_r, alive_nxt;
  logic [15:0]          thr_r;
  logic                 dv_r;
  logic [IDX_W-1:0]     didx_r;
  logic                 found_r, found_nxt;
  logic [16:0]          bkey_r, bkey_nxt;
  logic [IDX_W-1:0]     bidx_r, bidx_nxt;
  box_t                 bbox_r, bbox_nxt;
  logic [31:0]          barea_r, barea_nxt;
  logic                 ov_r, ov_nxt;
  box_t                 obox_r, obox_nxt;
  logic                 olast_r, olast_nxt, oovf_r, oovf_nxt;

  logic             in_fire, issue, ram_we;
  logic [IDX_W-1:0] ram_raddr;
  logic [BoxBits-1:0] ram_rdata;
  box_t             rbox, wbox;
  logic [16:0]      rkey;
  logic             res_v, res_sup, iou_busy;
  logic [IDX_W-1:0] res_idx;

  assign in_box.ready = (state_r == S_LOAD);
  assign in_fire      = in_box.valid && in_box.ready;
  assign ram_we       = in_fire && (count_r != CapCnt);
  assign wbox         = '{h: in_box.box_height, w: in_box.box_width,
                          y: in_box.box_y, x: in_box.box_x};
  assign issue        = (state_r == S_SCAN || state_r == S_SUPP) && (iss_r != count_r);
  assign ram_raddr    = iss_r[IDX_W-1:0];
  assign rbox         = box_t'(ram_rdata);
  assign rkey         = {1'b0, rbox.y} + {1'b0, rbox.h};

  nms_ram #(.WIDTH(BoxBits), .DEPTH(MAX_BOXES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wbox),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nms_iou #(.IDX_W(IDX_W)) u_iou (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (dv_r && (state_r == S_SUPP)),
    .in_idx    (didx_r),
    .other     (rbox),
    .kept      (bbox_r),
    .kept_area (barea_r),
    .thr       (thr_r),
    .res_v     (res_v),
    .res_idx   (res_idx),
    .res_sup   (res_sup),
    .busy      (iou_busy)
  );

  // Sequencer: load, scan for the best box, suppress, emit.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    iss_nxt   = issue ? iss_r + 1'b1 : iss_r;
    ovf_nxt   = ovf_r;
    alive_nxt = alive_r;
    found_nxt = found_r;
    bkey_nxt  = bkey_r;
    bidx_nxt  = bidx_r;
    bbox_nxt  = bbox_r;
    barea_nxt = barea_r;
    ov_nxt    = (out_box.valid && out_box.ready) ? 1'b0 : ov_r;
    obox_nxt  = obox_r;
    olast_nxt = olast_r;
    oovf_nxt  = oovf_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          if (count_r != CapCnt) begin
            alive_nxt[count_r[IDX_W-1:0]] = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_box.last_box) begin
            state_nxt = S_SCAN;
            iss_nxt   = '0;
            found_nxt = 1'b0;
          end
        end
      end
      S_SCAN: begin
        // Keep the alive box with the greatest bottom edge; ties go to the later one.
        if (dv_r && alive_r[didx_r] && (!found_r || rkey >= bkey_r)) begin
          found_nxt = 1'b1;
          bkey_nxt  = rkey;
          bidx_nxt  = didx_r;
          bbox_nxt  = rbox;
          barea_nxt = rbox.w * rbox.h;
        end
        if (!issue && !dv_r) begin
          alive_nxt[bidx_r] = 1'b0;
          state_nxt = S_SUPP;
          iss_nxt   = '0;
        end
      end
      S_SUPP: begin
        if (res_v && res_sup) begin
          alive_nxt[res_idx] = 1'b0;
        end
        if (!issue && !dv_r && !iou_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ov_r || out_box.ready) begin
          ov_nxt    = 1'b1;
          obox_nxt  = bbox_r;
          olast_nxt = ~|alive_r;
          oovf_nxt  = ovf_r;
          iss_nxt   = '0;
          found_nxt = 1'b0;
          if (~|alive_r) begin
            state_nxt = S_LOAD;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      iss_r   <= '0;
      ovf_r   <= 1'b0;
      alive_r <= '0;
      dv_r    <= 1'b0;
      found_r <= 1'b0;
      ov_r    <= 1'b0;
      thr_r   <= ThreshReset;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      iss_r   <= iss_nxt;
      ovf_r   <= ovf_nxt;
      alive_r <= alive_nxt;
      dv_r    <= issue;
      found_r <= found_nxt;
      ov_r    <= ov_nxt;
      if (cfg_thr.valid) begin
        thr_r <= cfg_thr.overlap_threshold;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    didx_r  <= iss_r[IDX_W-1:0];
    bkey_r  <= bkey_nxt;
    bidx_r  <= bidx_nxt;
    bbox_r  <= bbox_nxt;
    barea_r <= barea_nxt;
    obox_r  <= obox_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign cfg_thr.ready       = 1'b1;
  assign out_box.valid       = ov_r;
  assign out_box.kept_x      = obox_r.x;
  assign out_box.kept_y      = obox_r.y;
  assign out_box.kept_width  = obox_r.w;
  assign out_box.kept_height = obox_r.h;
  assign out_box.last_kept   = olast_r;
  assign out_box.overflow    = oovf_r;

  // The fill count never passes the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CapCnt) else $error("box count above capacity");

  // A scan only starts while some box is still alive.
  a_scan_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) ##1 (state_r == S_SCAN) |-> (|alive_r))
    else $error("scan started with no alive box");

  // A finished scan has always found a best box.
  a_scan_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && (state_nxt == S_SUPP) |-> found_r)
    else $error("scan ended without a best box");

  // Returning to loading follows the final kept beat being placed.
  a_last_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) && (state_nxt == S_LOAD) |=> (ov_r && olast_r && count_r == '0))
    else $error("set closed without final kept beat");

endmodule
